// ===== hw/rtl/spli_pkg.sv =====
// Shared types and constants for the speed-to-PWM calibration table interpolator.
// Used by spli_table, spli_muldiv and the top level; depends on nothing else.
package spli_pkg;

  // Field widths
  localparam int SPEED_W    = 23;
  localparam int PWM_W      = 17;
  localparam int CMD_W      = 24;
  localparam int OUT_PWM_W  = 18;
  localparam int REGION_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int SPD_THR_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int STEP_CW    = 5;

  // Default sizing
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_NUM_MOTORS  = 2;

  // Fixed-point constants
  localparam logic [PWM_W-1:0]     PWM_FULL    = 17'h10000;
  localparam logic [SPD_THR_W-1:0] SPD_THR_RST = 13'd1;
  localparam logic [PWM_W-1:0]     PWM_THR_RST = 17'd66;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_ZERO = 1'b0,
    CFG_PWM_ZERO   = 1'b1
  } cfg_reg_t;

  // Item kinds
  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } opcode_t;

  // Where a lookup landed
  typedef enum logic [REGION_W-1:0] {
    REGION_ZERO   = 3'd0,
    REGION_DEAD   = 3'd1,
    REGION_INTERP = 3'd2,
    REGION_FULL   = 3'd3,
    REGION_LOAD   = 3'd4
  } region_t;

  // One calibration entry
  typedef struct packed {
    logic [PWM_W-1:0]   pwm;
    logic [SPEED_W-1:0] speed;
  } entry_t;

  // Serial multiply-divide request and response
  typedef struct packed {
    logic               start;
    logic [SPEED_W-1:0] diff;
    logic [PWM_W-1:0]   dpmag;
    logic [SPEED_W-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [PWM_W-1:0] quot;
  } md_rsp_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  // Main sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_CHK,
    ST_CV_CHK,
    ST_CV_FIRST,
    ST_CV_LAST,
    ST_CV_SCAN,
    ST_CV_MD,
    ST_FIN,
    ST_OUT
  } ctl_state_t;

endpackage

// ===== hw/rtl/spli_table.sv =====
// Calibration table storage: single-port RAM of entries, registered read.
// Depends on spli_pkg for the entry type.
module spli_table #(
  parameter int DEPTH = spli_pkg::DEF_MAX_ENTRIES * spli_pkg::DEF_NUM_MOTORS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [AW-1:0]    addr,
  input  spli_pkg::entry_t wdata,
  output spli_pkg::entry_t rdata
);

  spli_pkg::entry_t mem [DEPTH];

  // One access per cycle, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/spli_muldiv.sv =====
// Bit-serial multiply then restoring divide: quot = (diff * dpmag) / den.
// One multiplier bit per cycle, then one quotient bit per cycle; uses spli_pkg.
module spli_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  spli_pkg::md_req_t req,
  output spli_pkg::md_rsp_t rsp
);

  localparam logic [spli_pkg::STEP_CW-1:0] LAST = spli_pkg::STEP_CW'(spli_pkg::PWM_W - 1);

  spli_pkg::md_state_t state, state_next;
  logic [spli_pkg::STEP_CW-1:0] cnt;
  // hi: upper partial product, later the partial remainder
  logic [spli_pkg::SPEED_W-1:0] hi;
  // lo: multiplier bits out, product low bits, then quotient bits in
  logic [spli_pkg::PWM_W-1:0]   lo;
  logic [spli_pkg::SPEED_W:0]   mul_sum;
  logic [spli_pkg::SPEED_W:0]   div_sh;
  logic [spli_pkg::SPEED_W:0]   div_sub;
  logic                         div_ge;

  assign mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, req.diff} : '0);
  assign div_sh  = {hi, lo[spli_pkg::PWM_W-1]};
  assign div_ge  = div_sh >= {1'b0, req.den};
  assign div_sub = div_sh - {1'b0, req.den};

  assign rsp.done = (state == spli_pkg::MD_DONE);
  assign rsp.quot = lo;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spli_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spli_pkg::MD_IDLE: begin
        if (req.start) state_next = spli_pkg::MD_MUL;
      end
      spli_pkg::MD_MUL: begin
        if (cnt == LAST) state_next = spli_pkg::MD_DIV;
      end
      spli_pkg::MD_DIV: begin
        if (cnt == LAST) state_next = spli_pkg::MD_DONE;
      end
      spli_pkg::MD_DONE: begin
        state_next = spli_pkg::MD_IDLE;
      end
      default: state_next = spli_pkg::MD_IDLE;
    endcase
  end

  // Shift-add, then shift-subtract; the quotient fits in PWM_W bits
  // because the product's upper part is already below den.
  always_ff @(posedge clk) begin
    case (state)
      spli_pkg::MD_IDLE: begin
        if (req.start) begin
          hi  <= '0;
          lo  <= req.dpmag;
          cnt <= '0;
        end
      end
      spli_pkg::MD_MUL: begin
        hi  <= mul_sum[spli_pkg::SPEED_W:1];
        lo  <= {mul_sum[0], lo[spli_pkg::PWM_W-1:1]};
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end
      spli_pkg::MD_DIV: begin
        hi  <= div_ge ? div_sub[spli_pkg::SPEED_W-1:0] : div_sh[spli_pkg::SPEED_W-1:0];
        lo  <= {lo[spli_pkg::PWM_W-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/speed_to_pwm_lut_interpolator.sv =====
// Speed-to-PWM calibration table interpolator, top level; uses spli_pkg, spli_table, spli_muldiv.
// Load beat: the table check and write run through ST_LD_RD and ST_LD_CHK, then ST_OUT.
// Convert beat: the table scan reads one entry per cycle, then the serial mul/div runs.
// One item in flight, so a new beat is taken only once the last one is through; the next is taken
// while a finished result waits in the output register.
// Reset clears the sequencer, entry counts and thresholds (1 and 66); table RAM is not cleared.
module speed_to_pwm_lut_interpolator #(
  parameter int MAX_ENTRIES = spli_pkg::DEF_MAX_ENTRIES,
  parameter int NUM_MOTORS  = spli_pkg::DEF_NUM_MOTORS
) (
  input  logic        clk,
  input  logic        rst,
  // Input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // entry_pwm[16:0], entry_speed[39:17], command_speed[63:40]
  input  logic [2:0]  s_tuser,   // opcode[0], motor[1], restart_table[2]
  // Result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pwm_out[17:0], table_count[22:18], zero[23]
  output logic [4:0]  m_tuser,   // motor_out[0], region[3:1], entry_accepted[4]
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spli_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH = NUM_MOTORS * MAX_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = spli_pkg::SPEED_W;
  localparam int PW    = spli_pkg::PWM_W;
  localparam int OW    = spli_pkg::OUT_PWM_W;

  spli_pkg::ctl_state_t state, state_next;

  // Captured item
  logic                 motor_q;
  logic                 restart_q;
  logic [PW-1:0]        epwm_q;
  logic [SW-1:0]        espeed_q;
  logic [spli_pkg::CMD_W-1:0] mag_q;
  logic                 neg_q;

  // Configuration
  logic [spli_pkg::SPD_THR_W-1:0] spd_thr;
  logic [PW-1:0]                  pwm_thr;

  // Per-motor fill counts
  logic [CW-1:0] kept_count [NUM_MOTORS];
  logic [CW-1:0] cur_count;
  logic          mvalid;

  // Lookup working registers
  logic [CW-1:0]    n_q;
  logic [CW-1:0]    n_m1;
  logic [CW-1:0]    ld_n;
  logic [CW-1:0]    ld_m1;
  logic [IW-1:0]    idx_q;
  spli_pkg::entry_t prv_q;
  logic [PW-1:0]    val_q;
  logic             dp_neg_q;

  // Result registers
  logic [OW-1:0]       res_pwm;
  spli_pkg::region_t   res_region;
  logic                res_acc;
  logic [CW-1:0]       res_count;
  logic [31:0]         cnt_ext;

  // Table RAM
  logic             mem_rd;
  logic             mem_wr;
  logic [IW-1:0]    mem_idx;
  logic [AW-1:0]    mem_base;
  logic [AW-1:0]    mem_addr;
  spli_pkg::entry_t mem_wdata;
  spli_pkg::entry_t mem_rdata;

  // Serial mul/div
  logic               md_start;
  logic [SW-1:0]      md_diff;
  logic [PW-1:0]      md_dpmag;
  logic [SW-1:0]      md_den;
  spli_pkg::md_req_t  md_req;
  spli_pkg::md_rsp_t  md_rsp;

  // Datapath helpers
  logic                 s_accept;
  logic                 out_free;
  logic                 ld_keep;
  logic                 cv_zero;
  logic                 found;
  logic [OW-1:0]        dp;
  logic [OW-1:0]        dp_mag;
  logic [OW-1:0]        q_sgn;
  logic [OW-1:0]        interp;
  logic [spli_pkg::CMD_W-1:0] cmd;
  logic [PW-1:0]        in_pwm;

  assign s_tready  = (state == spli_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid & s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign cmd    = s_tdata[63:40];
  assign in_pwm = s_tdata[16:0];

  // Count of the selected motor's table
  always_comb begin
    cur_count = '0;
    for (int t = 0; t < NUM_MOTORS; t++) begin
      if (32'(motor_q) == 32'(t)) cur_count = kept_count[t];
    end
  end

  assign mvalid = 32'(motor_q) < 32'(NUM_MOTORS);
  assign ld_n   = restart_q ? '0 : cur_count;
  assign ld_m1  = ld_n - CW'(1);
  assign n_m1   = n_q - CW'(1);

  assign ld_keep = (n_q < CW'(MAX_ENTRIES)) && ((n_q == '0) || (espeed_q > mem_rdata.speed));
  assign cv_zero = !mvalid || (mag_q == '0) || (mag_q < spli_pkg::CMD_W'(spd_thr))
                   || (cur_count == '0);
  assign found   = mag_q < {1'b0, mem_rdata.speed};

  // Slope and interpolated value
  assign dp     = {1'b0, mem_rdata.pwm} - {1'b0, prv_q.pwm};
  assign dp_mag = dp[OW-1] ? (OW'(0) - dp) : dp;
  assign q_sgn  = dp_neg_q ? (OW'(0) - {1'b0, md_rsp.quot}) : {1'b0, md_rsp.quot};
  assign interp = {1'b0, prv_q.pwm} + q_sgn;

  // RAM address: motor base plus entry index
  assign mem_base  = motor_q ? AW'(MAX_ENTRIES) : '0;
  assign mem_addr  = mem_base + AW'(mem_idx);
  assign mem_wdata = '{pwm: epwm_q, speed: espeed_q};

  assign md_req = '{start: md_start, diff: md_diff, dpmag: md_dpmag, den: md_den};

  spli_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .rd_en (mem_rd),
    .wr_en (mem_wr),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  spli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    mem_idx    = '0;
    unique case (state)
      spli_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = (spli_pkg::opcode_t'(s_tuser[0]) == spli_pkg::OP_LOAD)
                       ? spli_pkg::ST_LD_RD : spli_pkg::ST_CV_CHK;
        end
      end
      spli_pkg::ST_LD_RD: begin
        if (!mvalid) begin
          state_next = spli_pkg::ST_OUT;
        end else begin
          // fetch the last kept entry for the rising-speed check
          mem_rd     = (ld_n != '0);
          mem_idx    = ld_m1[IW-1:0];
          state_next = spli_pkg::ST_LD_CHK;
        end
      end
      spli_pkg::ST_LD_CHK: begin
        mem_wr     = ld_keep;
        mem_idx    = n_q[IW-1:0];
        state_next = spli_pkg::ST_OUT;
      end
      spli_pkg::ST_CV_CHK: begin
        if (cv_zero) begin
          state_next = spli_pkg::ST_OUT;
        end else begin
          mem_rd     = 1'b1;
          state_next = spli_pkg::ST_CV_FIRST;
        end
      end
      spli_pkg::ST_CV_FIRST: begin
        if (mag_q <= {1'b0, mem_rdata.speed}) begin
          state_next = spli_pkg::ST_FIN;
        end else begin
          mem_rd     = 1'b1;
          mem_idx    = n_m1[IW-1:0];
          state_next = spli_pkg::ST_CV_LAST;
        end
      end
      spli_pkg::ST_CV_LAST: begin
        if (mag_q >= {1'b0, mem_rdata.speed}) begin
          state_next = spli_pkg::ST_FIN;
        end else begin
          mem_rd     = 1'b1;
          mem_idx    = IW'(1);
          state_next = spli_pkg::ST_CV_SCAN;
        end
      end
      spli_pkg::ST_CV_SCAN: begin
        if (found) begin
          state_next = spli_pkg::ST_CV_MD;
        end else begin
          mem_rd  = 1'b1;
          mem_idx = idx_q + IW'(1);
        end
      end
      spli_pkg::ST_CV_MD: begin
        if (md_rsp.done) state_next = spli_pkg::ST_FIN;
      end
      spli_pkg::ST_FIN: begin
        state_next = spli_pkg::ST_OUT;
      end
      spli_pkg::ST_OUT: begin
        if (out_free) state_next = spli_pkg::ST_IDLE;
      end
      default: state_next = spli_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spd_thr <= spli_pkg::SPD_THR_RST;
      pwm_thr <= spli_pkg::PWM_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (spli_pkg::cfg_reg_t'(cfg_index))
        spli_pkg::CFG_SPEED_ZERO: spd_thr <= cfg_data[spli_pkg::SPD_THR_W-1:0];
        spli_pkg::CFG_PWM_ZERO:   pwm_thr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Fill counts; restart lands here through n_q
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_MOTORS; t++) kept_count[t] <= '0;
    end else if (state == spli_pkg::ST_LD_CHK) begin
      for (int t = 0; t < NUM_MOTORS; t++) begin
        if (32'(motor_q) == 32'(t)) kept_count[t] <= ld_keep ? n_q + CW'(1) : n_q;
      end
    end
  end

  // Mul/div start pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      md_start <= 1'b0;
    end else begin
      md_start <= (state == spli_pkg::ST_CV_SCAN) && found;
    end
  end

  // Item capture and lookup datapath
  always_ff @(posedge clk) begin
    case (state)
      spli_pkg::ST_IDLE: begin
        if (s_accept) begin
          motor_q   <= s_tuser[1];
          restart_q <= s_tuser[2];
          epwm_q    <= (in_pwm > spli_pkg::PWM_FULL) ? spli_pkg::PWM_FULL : in_pwm;
          espeed_q  <= s_tdata[39:17];
          neg_q     <= cmd[spli_pkg::CMD_W-1];
          mag_q     <= cmd[spli_pkg::CMD_W-1] ? (spli_pkg::CMD_W'(0) - cmd) : cmd;
        end
      end
      spli_pkg::ST_LD_RD: begin
        n_q        <= ld_n;
        res_pwm    <= '0;
        res_region <= spli_pkg::REGION_LOAD;
        res_acc    <= 1'b0;
        res_count  <= mvalid ? ld_n : '0;
      end
      spli_pkg::ST_LD_CHK: begin
        res_acc   <= ld_keep;
        res_count <= ld_keep ? n_q + CW'(1) : n_q;
      end
      spli_pkg::ST_CV_CHK: begin
        n_q        <= cur_count;
        res_pwm    <= '0;
        res_region <= spli_pkg::REGION_ZERO;
        res_acc    <= 1'b0;
        res_count  <= mvalid ? cur_count : '0;
      end
      spli_pkg::ST_CV_FIRST: begin
        if (mag_q <= {1'b0, mem_rdata.speed}) begin
          res_region <= spli_pkg::REGION_DEAD;
          val_q      <= mem_rdata.pwm;
        end else begin
          prv_q <= mem_rdata;
        end
      end
      spli_pkg::ST_CV_LAST: begin
        if (mag_q >= {1'b0, mem_rdata.speed}) begin
          res_region <= spli_pkg::REGION_FULL;
          val_q      <= spli_pkg::PWM_FULL;
        end else begin
          idx_q <= IW'(1);
        end
      end
      spli_pkg::ST_CV_SCAN: begin
        if (found) begin
          // bracket found: prv_q below, mem_rdata above
          res_region <= spli_pkg::REGION_INTERP;
          md_diff    <= mag_q[SW-1:0] - prv_q.speed;
          md_den     <= mem_rdata.speed - prv_q.speed;
          md_dpmag   <= dp_mag[PW-1:0];
          dp_neg_q   <= dp[OW-1];
        end else begin
          prv_q <= mem_rdata;
          idx_q <= idx_q + IW'(1);
        end
      end
      spli_pkg::ST_CV_MD: begin
        if (md_rsp.done) val_q <= interp[PW-1:0];
      end
      spli_pkg::ST_FIN: begin
        // sign back on, small magnitudes forced to zero
        if (val_q < pwm_thr) begin
          res_pwm <= '0;
        end else begin
          res_pwm <= neg_q ? (OW'(0) - {1'b0, val_q}) : {1'b0, val_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = 32'(res_count);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == spli_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spli_pkg::ST_OUT && out_free) begin
      m_tdata <= {1'b0, cnt_ext[spli_pkg::COUNT_W-1:0], res_pwm};
      m_tuser <= {res_acc, res_region, motor_q};
    end
  end

endmodule
